// ===== sv/rgb_to_yuv420_converter_top_macros.svh =====
// Assertion macros shared by the RGB to YUV 4:2:0 converter RTL.
// Needs a clk and an active-low rst_n in the scope of each use.
`ifndef RGB_TO_YUV420_CONVERTER_TOP_MACROS_SVH
`define RGB_TO_YUV420_CONVERTER_TOP_MACROS_SVH

// Checked only while out of reset.
`define R2Y_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define R2Y_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/r2y_pkg.sv =====
// Shared types and constants of the RGB to YUV 4:2:0 converter.
// No dependencies.
package r2y_pkg;

  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd1920;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd1080;

  // Coefficients, signed with 16 fraction bits.
  localparam logic signed [17:0] Y_R = 18'sd13933;
  localparam logic signed [17:0] Y_G = 18'sd46871;
  localparam logic signed [17:0] Y_B = 18'sd4732;
  localparam logic signed [17:0] U_R = -18'sd7510;
  localparam logic signed [17:0] U_G = -18'sd25258;
  localparam logic signed [17:0] U_B = 18'sd32768;
  localparam logic signed [17:0] V_R = 18'sd32768;
  localparam logic signed [17:0] V_G = -18'sd29766;
  localparam logic signed [17:0] V_B = -18'sd3002;

  localparam logic [7:0] LUMA_OFFSET   = 8'd0;
  localparam logic [7:0] CHROMA_OFFSET = 8'd128;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] chroma_u;
    logic [7:0] chroma_v;
    logic       chroma_valid;
    logic       frame_end;
  } yuv_t;

  typedef struct packed {
    logic chroma_valid;
    logic frame_end;
  } pos_flags_t;

endpackage

// ===== sv/rgb_to_yuv420_converter_top.sv =====
// Top level of the RGB to YUV 4:2:0 converter: input register, color mix, result register.
// Depends on r2y_pkg, r2y_pos_tracker, r2y_color_mix and the assertion macro header.
//
// Usage:
//   Input channel in_valid/in_stall/in_data carries one RGB pixel per item in raster
//   order. Output channel out_valid/out_stall/out_data gives one item per pixel: luma,
//   chroma U/V (zero unless chroma_valid), chroma_valid on even column and even row,
//   and frame_end on the last pixel of the frame.
//   cfg_we/cfg_index/cfg_wdata write image_width (index 0) and image_height (index 1);
//   write only while the block holds no items. Dimensions clamp to 2..MAX_DIM.
//   An accepted item is held in the input register and then in the result register.
//   Throughput: one item per cycle while out_stall is low, set by the input register
//   feeding the combinational color matrix into the result register.
//   Reset (rst_n low, synchronous): pipeline emptied, counters to frame start,
//   width 1920, height 1080.
//   Output stall: the result register holds; the input register still takes one more
//   item, after which in_stall follows out_stall.
`include "rgb_to_yuv420_converter_top_macros.svh"

module rgb_to_yuv420_converter_top #(
  parameter int MAX_DIM = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  r2y_pkg::pix_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output r2y_pkg::yuv_t                 out_data,
  input  logic                          cfg_we,
  input  logic [r2y_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [r2y_pkg::CFG_W-1:0]     cfg_wdata
);
  import r2y_pkg::*;

  logic       s1_valid_r, s1_valid_nxt;
  pix_t       s1_pix_r;
  pos_flags_t s1_flags_r, pos_flags;
  logic       out_valid_r, out_valid_nxt;
  yuv_t       out_data_r, mix_yuv;
  logic       advance, in_accept;

  assign advance   = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  r2y_pos_tracker #(
    .MAX_DIM (MAX_DIM)
  ) u_pos (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .advance   (in_accept),
    .flags     (pos_flags)
  );

  r2y_color_mix u_mix (
    .pix   (s1_pix_r),
    .flags (s1_flags_r),
    .yuv   (mix_yuv)
  );

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = s1_valid_r;
      s1_valid_nxt  = in_accept;
    end else if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_pix_r   <= in_data;
      s1_flags_r <= pos_flags;
    end
    if (advance && s1_valid_r) begin
      out_data_r <= mix_yuv;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `R2Y_ASSERT(a_stall_only_when_full, in_stall |-> s1_valid_r, "input stalled with empty stage")
  `R2Y_ASSERT(a_item_moves_on, (s1_valid_r && advance) |=> out_valid_r, "item lost")
  `R2Y_ASSERT(a_chroma_zero, (out_valid_r && !out_data_r.chroma_valid) |-> (out_data_r.chroma_u == 8'd0 && out_data_r.chroma_v == 8'd0), "chroma not zeroed")
  `R2Y_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (!out_valid_r && !s1_valid_r), "pipeline not empty after reset")

endmodule

// ===== sv/r2y_pos_tracker.sv =====
// Frame position tracker: dimension registers, column and row counters.
// Depends on r2y_pkg.
module r2y_pos_tracker #(
  parameter int MAX_DIM = 4096
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [r2y_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [r2y_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic                         advance,
  output r2y_pkg::pos_flags_t          flags
);
  import r2y_pkg::*;

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int CNT_W = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
  localparam int CMP_W = (CFG_W > DIM_W) ? CFG_W : DIM_W;

  logic [CFG_W-1:0] width_r, height_r;
  logic [CNT_W-1:0] col_r, col_nxt, row_r, row_nxt;
  logic [DIM_W-1:0] w_dim, h_dim, col_ext, row_ext;
  logic             last_col, last_row;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    logic [CMP_W-1:0] e;
    logic [CMP_W-1:0] res;
    e = CMP_W'(v);
    if (e < CMP_W'(2))            res = CMP_W'(2);
    else if (e > CMP_W'(MAX_DIM)) res = CMP_W'(MAX_DIM);
    else                          res = e;
    return DIM_W'(res);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_wdata;
        REG_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign w_dim    = clamp_dim(width_r);
  assign h_dim    = clamp_dim(height_r);
  assign col_ext  = DIM_W'(col_r);
  assign row_ext  = DIM_W'(row_r);
  assign last_col = col_ext >= (w_dim - DIM_W'(1));
  assign last_row = row_ext >= (h_dim - DIM_W'(1));

  assign flags.chroma_valid = !col_r[0] && !row_r[0];
  assign flags.frame_end    = last_col && last_row;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (advance) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + CNT_W'(1);
      end else begin
        col_nxt = col_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

// ===== sv/r2y_color_mix.sv =====
// Fixed-point color matrix: RGB to Y, U, V with floor and saturation.
// Depends on r2y_pkg.
module r2y_color_mix (
  input  r2y_pkg::pix_t       pix,
  input  r2y_pkg::pos_flags_t flags,
  output r2y_pkg::yuv_t       yuv
);
  import r2y_pkg::*;

  function automatic logic [7:0] mix8(
    input logic signed [17:0] cr,
    input logic signed [17:0] cg,
    input logic signed [17:0] cb,
    input logic [7:0]         off,
    input logic [7:0]         r,
    input logic [7:0]         g,
    input logic [7:0]         b
  );
    logic signed [31:0] rw, gw, bw, ow, s;
    logic [7:0]         res;
    rw = signed'({24'd0, r});
    gw = signed'({24'd0, g});
    bw = signed'({24'd0, b});
    ow = signed'({8'd0, off, 16'd0});
    s  = cr * rw + cg * gw + cb * bw + ow;
    if (s < 0)                    res = 8'd0;
    else if (s[31:16] > 16'd255)  res = 8'd255;
    else                          res = s[23:16];
    return res;
  endfunction

  logic [7:0] u_full, v_full;

  assign u_full = mix8(U_R, U_G, U_B, CHROMA_OFFSET, pix.red, pix.green, pix.blue);
  assign v_full = mix8(V_R, V_G, V_B, CHROMA_OFFSET, pix.red, pix.green, pix.blue);

  assign yuv.luma         = mix8(Y_R, Y_G, Y_B, LUMA_OFFSET, pix.red, pix.green, pix.blue);
  assign yuv.chroma_u     = flags.chroma_valid ? u_full : 8'd0;
  assign yuv.chroma_v     = flags.chroma_valid ? v_full : 8'd0;
  assign yuv.chroma_valid = flags.chroma_valid;
  assign yuv.frame_end    = flags.frame_end;

endmodule
